@@ src/grmd_pkg.sv @@
// Package for the glucose rise meal detector.
// Holds field widths, register indexes, result codes and saturation.
// No dependencies.
`timescale 1ns / 1ps

package grmd_pkg;

    localparam int LEVEL_W = 16;
    localparam int TIME_W  = 32;
    localparam int THR_W   = 15;
    localparam int ACT_W   = 16;
    localparam int ACC_W   = 24;
    localparam int PROD_W  = 48;
    localparam int NUM_W   = 24;
    localparam int DEN_W   = 33;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_RATE_LO = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RATE_HI = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_W_LO    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_W_HI    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HIST    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DET_LO  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DET_HI  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_MODE    = 3'd7;

    // Carbohydrate levels.
    localparam logic [1:0] CARB_NONE     = 2'd0;
    localparam logic [1:0] CARB_PROBABLE = 2'd1;
    localparam logic [1:0] CARB_DETECTED = 2'd2;

    // Ceiling of 2^24 / 10, exact for dividends below 2^22.
    localparam int RECIP_SHIFT = 24;
    localparam logic [20:0] RECIP_TEN = 21'd1677722;

    // Clamp a wide signed value to the signed 16-bit range.
    function automatic logic signed [ACT_W-1:0] sat_act(input logic signed [ACC_W-1:0] v);
        logic signed [ACT_W-1:0] r;
        if (v > $signed(ACC_W'(32767))) begin
            r = 16'sh7FFF;
        end else if (v < -$signed(ACC_W'(32768))) begin
            r = 16'sh8000;
        end else begin
            r = v[ACT_W-1:0];
        end
        return r;
    endfunction

endpackage

@@ src/grmd_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module grmd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 12
) (
    input  logic                                   aclk,
    input  logic                                   wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

@@ src/grmd_bonus.sv @@
// Bonus scaler: computes round(0.1 * sum) in Q8.8 with a reciprocal multiply.
// Depends on grmd_pkg.
`timescale 1ns / 1ps

module grmd_bonus #(
    parameter int SUM_W = 13
) (
    input  logic               aclk,
    input  logic [SUM_W-1:0]   sum,
    output logic [SUM_W+5:0]   bonus
);
    import grmd_pkg::*;

    localparam int X_W = SUM_W + 9;
    localparam int P_W = X_W + 21;

    logic [X_W-1:0] x;
    logic [P_W-1:0] prod;

    // (sum * 256 + 5) / 10, the divide done as a multiply by the reciprocal.
    assign x    = {1'b0, sum, 8'h00} + X_W'(5);
    assign prod = P_W'(x) * P_W'(RECIP_TEN);

    always_ff @(posedge aclk) begin
        bonus <= prod[RECIP_SHIFT +: SUM_W + 6];
    end

endmodule

@@ src/glucose_rise_meal_detector_unit.sv @@
// Glucose rise meal detector, top level.
// A sample passes two threshold multiplies, then one walk over the history RAM at one entry
// per cycle, then the bonus and final steps. A first sample or a request with detection off
// is reported from the start step instead. One request at a time: the next is taken in idle,
// once the result is registered; a segment stop returns to idle without a result. Reset
// (aresetn, synchronous) restores register defaults and clears the history fill count; no
// clearing pass.
`timescale 1ns / 1ps

module glucose_rise_meal_detector_unit #(
    parameter int HISTORY_DEPTH = 12,
    parameter int PEAK_SPAN     = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // glucose_level [15:0], sample_time [47:16]
    input  logic [0:0]  s_tuser,   // action [0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // activation_value [15:0], carb_level [17:16], zero
    output logic [0:0]  m_tuser,   // activation_valid [0]
    input  logic        cfg_wr_en,
    input  logic [grmd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [grmd_pkg::CFG_DATA_W-1:0] cfg_data
);
    import grmd_pkg::*;

    localparam int IDX_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
    localparam int SUM_W = $clog2(HISTORY_DEPTH * HISTORY_DEPTH + 1);
    localparam int BON_W = SUM_W + 6;
    localparam int AD_W  = IDX_W + 2;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_START = 4'd1;
    localparam logic [3:0] ST_PREP  = 4'd2;
    localparam logic [3:0] ST_MUL   = 4'd3;
    localparam logic [3:0] ST_CMP   = 4'd4;
    localparam logic [3:0] ST_WALK  = 4'd5;
    localparam logic [3:0] ST_BONUS = 4'd6;
    localparam logic [3:0] ST_FINAL = 4'd7;

    // Configuration registers.
    logic [THR_W-1:0]        rate_lo_reg, rate_hi_reg, w_lo_reg, w_hi_reg, hist_thr_reg;
    logic signed [ACT_W-1:0] det_lo_reg, det_hi_reg;
    logic [1:0]              mode_reg;

    // Control and state.
    logic [3:0]        state_reg, state_next;
    logic              started_reg;
    logic [LEVEL_W-1:0] last_level_reg;
    logic [TIME_W-1:0]  last_time_reg;
    logic [CNT_W-1:0]  fill_reg;
    logic [IDX_W-1:0]  wp_reg;

    // Per-request working registers.
    logic                     in_action_reg;
    logic [LEVEL_W-1:0]       in_level_reg;
    logic [TIME_W-1:0]        in_time_reg;
    logic signed [LEVEL_W:0]  dl_reg;
    logic signed [TIME_W:0]   dt_reg;
    logic signed [NUM_W-1:0]  num_reg;
    logic [DEN_W-1:0]         den_reg;
    logic [PROD_W-1:0]        prod_reg;
    logic                     tsel_reg;
    logic signed [ACC_W-1:0]  act_reg, actm_reg;
    logic                     rise_br_reg, fall_br_reg;
    logic [CNT_W-1:0]         i_reg, pidx_reg;
    logic                     pend_reg;
    logic [SUM_W-1:0]         sum_reg;
    logic signed [ACT_W-1:0]  peak_reg;

    // Result register.
    logic                     m_tvalid_reg, m_flag_reg;
    logic signed [ACT_W-1:0]  m_value_reg;
    logic [1:0]               m_carb_reg;

    logic out_free;
    logic res_load;
    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'd0, m_carb_reg, m_value_reg};
    assign m_tuser  = m_flag_reg;

    // A new result is loaded into the result register in this cycle.
    assign res_load = out_free && ((state_reg == ST_FINAL)
                      || ((state_reg == ST_START) && !in_action_reg
                          && (!mode_reg[0] || !started_reg)));

    // Level difference widened to the numerator width.
    logic signed [NUM_W-1:0] dl_ext;
    assign dl_ext = NUM_W'(dl_reg);

    // History RAM: rise entry in the upper half, fall entry in the lower half.
    logic                 ram_we;
    logic [IDX_W-1:0]     ram_raddr;
    logic [2*ACT_W-1:0]   ram_wdata, ram_rdata;

    grmd_ram #(.WIDTH(2 * ACT_W), .DEPTH(HISTORY_DEPTH)) u_hist (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (wp_reg),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // Bonus scaler, result registered in the cycle after the sum settles.
    logic [BON_W-1:0] bonus;

    grmd_bonus #(.SUM_W(SUM_W)) u_bonus (
        .aclk  (aclk),
        .sum   (sum_reg),
        .bonus (bonus)
    );

    // Entry i (0 newest) sits at wp - 1 - i, wrapped.
    logic [AD_W-1:0] addr_raw, addr_wrap;
    always_comb begin
        addr_raw  = AD_W'(wp_reg) + AD_W'(HISTORY_DEPTH - 1) - AD_W'(i_reg);
        addr_wrap = (addr_raw >= AD_W'(HISTORY_DEPTH)) ? addr_raw - AD_W'(HISTORY_DEPTH)
                                                       : addr_raw;
        ram_raddr = addr_wrap[IDX_W-1:0];
    end

    // Threshold product and comparisons.
    logic [THR_W-1:0]        thr_sel, w_sel;
    logic [PROD_W-1:0]       prod_next;
    logic signed [PROD_W:0]  num_ext, prod_s;
    logic                    num_gt, num_lt;
    always_comb begin
        thr_sel   = tsel_reg ? rate_hi_reg : rate_lo_reg;
        w_sel     = tsel_reg ? w_hi_reg : w_lo_reg;
        prod_next = PROD_W'(thr_sel) * PROD_W'(den_reg);
        num_ext   = {{(PROD_W + 1 - NUM_W){num_reg[NUM_W-1]}}, num_reg};
        prod_s    = {1'b0, prod_reg};
        num_gt    = num_ext > prod_s;
        num_lt    = num_ext < -prod_s;
    end

    // History tests on the entry read back from the RAM.
    logic signed [ACT_W-1:0] r_val, f_val;
    logic signed [23:0]      r5, f5, thrv;
    logic                    rise_hit, fall_hit, peak_take;
    always_comb begin
        r_val = ram_rdata[2*ACT_W-1:ACT_W];
        f_val = ram_rdata[ACT_W-1:0];
        r5    = {{8{r_val[ACT_W-1]}}, r_val} * 24'sd5;
        f5    = {{8{f_val[ACT_W-1]}}, f_val} * 24'sd5;
        thrv  = $signed(24'(hist_thr_reg) * 24'd5 + (24'(pidx_reg) << 8));
        rise_hit  = r5 >= thrv;
        fall_hit  = f5 <= -thrv;
        peak_take = (32'(pidx_reg) < 32'(PEAK_SPAN))
                    && ((pidx_reg == '0) || (r_val > peak_reg));
    end

    // Final activation with bonus and saturation.
    logic signed [ACC_W-1:0] bon_s, act_f, actm_f;
    logic signed [ACT_W-1:0] act_sat, actm_sat;
    always_comb begin
        bon_s = $signed(ACC_W'(bonus));
        if (rise_br_reg) begin
            act_f  = act_reg + bon_s;
            actm_f = actm_reg;
        end else if (fall_br_reg) begin
            act_f  = {{(ACC_W - ACT_W){peak_reg[ACT_W-1]}}, peak_reg} - bon_s;
            actm_f = actm_reg - bon_s;
        end else begin
            act_f  = act_reg;
            actm_f = actm_reg;
        end
        act_sat   = sat_act(act_f);
        actm_sat  = sat_act(actm_f);
        ram_wdata = {act_sat, actm_sat};
        ram_we    = (state_reg == ST_FINAL) && out_free;
    end

    // Carbohydrate level of the activation reported at this step.
    logic signed [ACT_W-1:0] carb_in;
    logic [1:0]              carb;
    always_comb begin
        carb_in = (state_reg == ST_FINAL) ? act_sat : '0;
        if (carb_in > det_hi_reg) begin
            carb = CARB_DETECTED;
        end else if (carb_in > det_lo_reg) begin
            carb = CARB_PROBABLE;
        end else begin
            carb = CARB_NONE;
        end
    end

    // Sequencer.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (s_tvalid) state_next = ST_START;
            ST_START: begin
                if (in_action_reg) begin
                    state_next = ST_IDLE;
                end else if (!mode_reg[0] || !started_reg) begin
                    if (out_free) state_next = ST_IDLE;
                end else begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:  state_next = ST_MUL;
            ST_MUL:   state_next = ST_CMP;
            ST_CMP:   state_next = tsel_reg ? ST_WALK : ST_MUL;
            ST_WALK:  if (i_reg == fill_reg && !pend_reg) state_next = ST_BONUS;
            ST_BONUS: state_next = ST_FINAL;
            ST_FINAL: if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rate_lo_reg    <= THR_W'(26);
            rate_hi_reg    <= THR_W'(51);
            w_lo_reg       <= THR_W'(256);
            w_hi_reg       <= THR_W'(512);
            hist_thr_reg   <= THR_W'(512);
            det_lo_reg     <= 16'sd256;
            det_hi_reg     <= 16'sd512;
            mode_reg       <= 2'b11;
            state_reg      <= ST_IDLE;
            started_reg    <= 1'b0;
            last_level_reg <= '0;
            last_time_reg  <= '0;
            fill_reg       <= '0;
            wp_reg         <= '0;
            m_tvalid_reg   <= 1'b0;
            pend_reg       <= 1'b0;
        end else begin
            state_reg <= state_next;

            // Configuration writes.
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_RATE_LO: rate_lo_reg  <= cfg_data[THR_W-1:0];
                    REG_RATE_HI: rate_hi_reg  <= cfg_data[THR_W-1:0];
                    REG_W_LO:    w_lo_reg     <= cfg_data[THR_W-1:0];
                    REG_W_HI:    w_hi_reg     <= cfg_data[THR_W-1:0];
                    REG_HIST:    hist_thr_reg <= cfg_data[THR_W-1:0];
                    REG_DET_LO:  det_lo_reg   <= $signed(cfg_data);
                    REG_DET_HI:  det_hi_reg   <= $signed(cfg_data);
                    REG_MODE:    mode_reg     <= cfg_data[1:0];
                    default:     ;
                endcase
            end

            if (m_tvalid_reg && m_tready && !res_load) begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        in_action_reg <= s_tuser[0];
                        in_level_reg  <= s_tdata[15:0];
                        in_time_reg   <= s_tdata[47:16];
                    end
                end
                ST_START: begin
                    dl_reg   <= $signed({1'b0, in_level_reg}) - $signed({1'b0, last_level_reg});
                    dt_reg   <= $signed({1'b0, in_time_reg}) - $signed({1'b0, last_time_reg});
                    tsel_reg <= 1'b0;
                    act_reg  <= '0;
                    actm_reg <= '0;
                    if (in_action_reg) begin
                        started_reg    <= 1'b0;
                        last_level_reg <= '0;
                        last_time_reg  <= '0;
                        fill_reg       <= '0;
                    end else if (!mode_reg[0] && out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_flag_reg   <= 1'b0;
                        m_value_reg  <= '0;
                        m_carb_reg   <= CARB_NONE;
                    end else if (!started_reg && out_free) begin
                        started_reg    <= 1'b1;
                        last_level_reg <= in_level_reg;
                        last_time_reg  <= in_time_reg;
                        m_tvalid_reg   <= 1'b1;
                        m_flag_reg     <= 1'b1;
                        m_value_reg    <= '0;
                        m_carb_reg     <= carb;
                    end
                end
                ST_PREP: begin
                    // Rate numerator 60 * dl, sign moved onto it so the gap is positive.
                    if (dt_reg < 0) begin
                        num_reg <= -((dl_ext <<< 6) - (dl_ext <<< 2));
                        den_reg <= DEN_W'(-dt_reg);
                    end else begin
                        num_reg <= (dl_ext <<< 6) - (dl_ext <<< 2);
                        den_reg <= DEN_W'(dt_reg);
                    end
                end
                ST_MUL: prod_reg <= prod_next;
                ST_CMP: begin
                    if (den_reg != '0) begin
                        if (num_gt) act_reg  <= $signed(ACC_W'(w_sel));
                        if (num_lt) actm_reg <= -$signed(ACC_W'(w_sel));
                    end
                    tsel_reg <= 1'b1;
                    i_reg    <= '0;
                    pend_reg <= 1'b0;
                    sum_reg  <= '0;
                    peak_reg <= '0;
                    if (tsel_reg) begin
                        rise_br_reg <= 1'b0;
                        fall_br_reg <= 1'b0;
                    end
                end
                ST_WALK: begin
                    // Branch decided on the first walk cycle from the final weights.
                    if (i_reg == '0 && !pend_reg) begin
                        rise_br_reg <= act_reg >= $signed(ACC_W'(w_lo_reg));
                        fall_br_reg <= !(act_reg >= $signed(ACC_W'(w_lo_reg))) && mode_reg[1]
                                       && (actm_reg <= -$signed(ACC_W'(w_lo_reg)));
                    end
                    if (i_reg != fill_reg) begin
                        i_reg    <= i_reg + 1'b1;
                        pidx_reg <= i_reg;
                        pend_reg <= 1'b1;
                    end else begin
                        pend_reg <= 1'b0;
                    end
                    if (pend_reg) begin
                        if (rise_br_reg && rise_hit) sum_reg <= sum_reg + SUM_W'(pidx_reg);
                        if (fall_br_reg && fall_hit) sum_reg <= sum_reg + SUM_W'(pidx_reg);
                        if (peak_take) peak_reg <= r_val;
                    end
                end
                ST_BONUS: ;
                ST_FINAL: begin
                    if (out_free) begin
                        wp_reg <= (wp_reg == IDX_W'(HISTORY_DEPTH - 1)) ? '0 : wp_reg + 1'b1;
                        if (fill_reg != CNT_W'(HISTORY_DEPTH)) fill_reg <= fill_reg + 1'b1;
                        last_level_reg <= in_level_reg;
                        last_time_reg  <= in_time_reg;
                        m_tvalid_reg   <= 1'b1;
                        m_flag_reg     <= 1'b1;
                        m_value_reg    <= act_sat;
                        m_carb_reg     <= carb;
                    end
                end
                default: ;
            endcase
        end
    end

endmodule
